/* hdl/pin_edge_event_and_pulse_counter_defines.svh */
// Assertion macros shared by the pin edge event and pulse counter RTL.
`ifndef PIN_EDGE_EVENT_AND_PULSE_COUNTER_DEFINES_SVH
`define PIN_EDGE_EVENT_AND_PULSE_COUNTER_DEFINES_SVH
`ifndef ASSERT_OFF
`define PEPC_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
		else $error("pepc assertion failed");
`define PEPC_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
		else $error("pepc assertion failed");
`else
`define PEPC_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons)
`define PEPC_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons)
`endif
`endif

/* hdl/pepc_pkg.sv */
// Types and constants of the pin edge event and pulse counter.
package pepc_pkg;

	typedef enum logic [1:0] {
		OP_SAMPLE = 2'd0,
		OP_READ   = 2'd1,
		OP_CLEAR  = 2'd2
	} op_t;

	localparam logic [1:0] MODE_EVENT   = 2'd1;
	localparam logic [1:0] MODE_COUNTER = 2'd2;

	// Channel i watches port bit PORT_MSB - i.
	localparam int PORT_MSB = 7;

	localparam int IN_TDATA_W  = 48;
	localparam int OUT_TDATA_W = 104;

	typedef struct packed {
		logic        level;
		logic [31:0] stamp;
		logic [31:0] count;
	} lane_state_t;

	typedef struct packed {
		logic sample;
		logic clear_count;
	} lane_ctrl_t;

	// Packed so that event_pending sits in the lowest bit.
	typedef struct packed {
		logic [31:0] samples_seen;
		logic [31:0] count;
		logic [31:0] stamp;
		logic        level;
		logic        event_pending;
	} result_t;

endpackage

/* hdl/pepc_lane.sv */
// One channel lane: edge detection, captured level and stamp, edge counter.
module pepc_lane
	import pepc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic [1:0]  mode,
	input  lane_ctrl_t  ctrl,
	input  logic        prev_bit,
	input  logic        new_bit,
	input  logic [31:0] time_ms,
	output lane_state_t state,
	output logic        event_hit
);

	logic        level_q;
	logic [31:0] stamp_q;
	logic [31:0] count_q;
	logic        rise;

	assign event_hit = ctrl.sample && (mode == MODE_EVENT) && (prev_bit != new_bit);
	assign rise      = ctrl.sample && (mode == MODE_COUNTER) && !prev_bit && new_bit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= 1'b0;
			stamp_q <= '0;
			count_q <= '0;
		end else begin
			if (event_hit) begin
				level_q <= new_bit;
				stamp_q <= time_ms;
			end
			if (rise) begin
				count_q <= count_q + 32'd1;
			end else if (ctrl.clear_count) begin
				count_q <= '0;
			end
		end
	end

	assign state.level = level_q;
	assign state.stamp = stamp_q;
	assign state.count = count_q;

endmodule

/* hdl/pepc_merge.sv */
// Merges the lanes: selects the read channel and ORs the event hits.
module pepc_merge
	import pepc_pkg::*;
#(
	parameter int CHANNELS = 8
)(
	input  lane_state_t          lanes [CHANNELS],
	input  logic [CHANNELS-1:0]  hits,
	input  logic [2:0]           channel,
	input  logic                 is_read,
	output lane_state_t          sel,
	output logic                 any_hit
);

	// A channel number beyond the lanes matches none and reads as zero.
	always_comb begin
		sel = '0;
		if (is_read) begin
			for (int i = 0; i < CHANNELS; i++) begin
				if (channel == 3'(i)) begin
					sel = lanes[i];
				end
			end
		end
	end

	assign any_hit = |hits;

endmodule

/* hdl/pin_edge_event_and_pulse_counter.sv */
// Pin edge event capture and pulse counter: top level.
// A result beat is registered and appears in the cycle after its input beat is accepted.
// Throughput: one beat per cycle while the output is not stalled; all lanes update in the cycle of acceptance.
// The single output register stays full under stall while the input waits.
// Reset clears the channel modes, all lane state, the pending flag and the
// sample counter at once; no clearing pass is needed.
`include "pin_edge_event_and_pulse_counter_defines.svh"
module pin_edge_event_and_pulse_counter
	import pepc_pkg::*;
#(
	parameter int CHANNELS = 8
)(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wr_en,
	input  logic [15:0]            cfg_wr_data,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// port_bits[7:0], time_ms[39:8], channel[42:40], zero fill
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	// operation[1:0]
	input  logic [1:0]             s_axis_tuser,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// event_pending[0], level[1], stamp[33:2], count[65:34],
	// samples_seen[97:66], zero fill
	output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

	logic [15:0]         modes_q;
	logic [7:0]          prev_port_q;
	logic                pending_q;
	logic [31:0]         samples_q;
	logic                out_valid_q;
	result_t             result_q;

	logic [7:0]          in_port;
	logic [31:0]         in_time;
	logic [2:0]          in_channel;
	logic                s_acc;
	logic                is_sample;
	logic                is_read;
	logic                is_clear;
	logic                pending_d;
	logic [31:0]         samples_d;
	lane_state_t         lanes [CHANNELS];
	logic [CHANNELS-1:0] hits;
	lane_state_t         sel;
	logic                any_hit;
	result_t             result_d;

	assign in_port    = s_axis_tdata[7:0];
	assign in_time    = s_axis_tdata[39:8];
	assign in_channel = s_axis_tdata[42:40];

	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign s_acc         = s_axis_tvalid && s_axis_tready;
	assign is_sample     = (s_axis_tuser == OP_SAMPLE);
	assign is_read       = (s_axis_tuser == OP_READ);
	assign is_clear      = (s_axis_tuser == OP_CLEAR);

	for (genvar i = 0; i < CHANNELS; i++) begin : g_lane
		lane_ctrl_t ctrl;
		assign ctrl.sample      = s_acc && is_sample;
		assign ctrl.clear_count = s_acc && is_read && (in_channel == 3'(i));

		pepc_lane u_lane (
			.clk       (clk),
			.arst_n    (arst_n),
			.mode      (modes_q[2*i +: 2]),
			.ctrl      (ctrl),
			.prev_bit  (prev_port_q[PORT_MSB-i]),
			.new_bit   (in_port[PORT_MSB-i]),
			.time_ms   (in_time),
			.state     (lanes[i]),
			.event_hit (hits[i])
		);
	end

	pepc_merge #(
		.CHANNELS (CHANNELS)
	) u_merge (
		.lanes   (lanes),
		.hits    (hits),
		.channel (in_channel),
		.is_read (is_read),
		.sel     (sel),
		.any_hit (any_hit)
	);

	always_comb begin
		case (s_axis_tuser)
			OP_SAMPLE: pending_d = pending_q || any_hit;
			OP_CLEAR:  pending_d = 1'b0;
			default:   pending_d = pending_q;
		endcase
	end

	assign samples_d = samples_q + 32'(is_sample);

	always_comb begin
		result_d.event_pending = pending_d;
		result_d.level         = sel.level;
		result_d.stamp         = sel.stamp;
		result_d.count         = sel.count;
		result_d.samples_seen  = samples_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modes_q     <= '0;
			prev_port_q <= '0;
			pending_q   <= 1'b0;
			samples_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				modes_q <= cfg_wr_data;
			end
			if (s_acc) begin
				pending_q <= pending_d;
				samples_q <= samples_d;
				if (is_sample) begin
					prev_port_q <= in_port;
				end
			end
			if (s_acc) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			result_q <= result_d;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {(OUT_TDATA_W - $bits(result_t))'(0), result_q};

	`PEPC_ASSERT_NEXT(a_sample_counts, clk, arst_n, s_acc && is_sample, samples_q == $past(samples_q) + 32'd1)
	`PEPC_ASSERT_NEXT(a_clear_drops_pending, clk, arst_n, s_acc && is_clear, !pending_q)
	`PEPC_ASSERT_NEXT(a_accept_gives_result, clk, arst_n, s_acc, m_axis_tvalid)
	`PEPC_ASSERT_NEXT(a_foreign_read_zero, clk, arst_n, s_acc && is_read && ({1'b0, in_channel} >= 4'(CHANNELS)), result_q.count == 32'd0 && result_q.stamp == 32'd0)

endmodule

/* tb/tb_top.sv */
// Testbench for the pin edge event and pulse counter: directed table, random phases, predictor.
`timescale 1ns / 1ps
module tb_top;
	import pepc_pkg::*;

	localparam int NUM_CH = 8;
	localparam int CYCLE_LIMIT = 200000;
	localparam int IDLE_PCT = 20;
	localparam int RANDOM_PHASES = 10;
	localparam int ITEMS_PER_PHASE = 155;
	// Operation code that the block must accept and leave without effect.
	localparam logic [1:0] OP_UNUSED = 2'd3;

	typedef struct {
		bit          is_cfg;
		logic [15:0] modes;
		logic [1:0]  op;
		logic [7:0]  port;
		logic [31:0] tms;
		logic [2:0]  ch;
		bit          fixed;
		result_t     res;
	} stim_row_t;

	logic                   clk;
	logic                   arst_n = 1'b0;
	logic                   cfg_wr_en = 1'b0;
	logic [15:0]            cfg_wr_data = '0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
	logic [1:0]             s_axis_tuser = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;

	// Travels with each beat: a typed-in expectation replaces the predicted one.
	bit      row_fixed = 1'b0;
	result_t row_res = '0;
	bit      quiet = 1'b0;

	// Predictor state.
	logic [15:0] chan_modes;
	logic [7:0]  prev_port;
	logic        lvl_mem [NUM_CH];
	logic [31:0] stamp_mem [NUM_CH];
	logic [31:0] edges_mem [NUM_CH];
	logic        pend;
	logic [31:0] sample_total;

	result_t   results_due [$];
	stim_row_t stim_rows [$];
	int        errors = 0;
	int        cycle_cnt = 0;
	logic [7:0]  last_port = '0;
	logic [31:0] now_ms = '0;

	pin_edge_event_and_pulse_counter #(.CHANNELS(NUM_CH)) uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic result_t mk_res(logic pe, logic lv, logic [31:0] st, logic [31:0] cn,
			logic [31:0] sm);
		result_t r;
		r.event_pending = pe;
		r.level = lv;
		r.stamp = st;
		r.count = cn;
		r.samples_seen = sm;
		return r;
	endfunction

	function automatic result_t counter_result(logic [1:0] op, logic [7:0] port,
			logic [31:0] tms, logic [2:0] ch);
		result_t    r;
		logic [1:0] m;
		logic       was, now_b;
		r = '0;
		case (op)
			OP_SAMPLE: begin
				for (int i = 0; i < NUM_CH; i++) begin
					m = chan_modes[2*i +: 2];
					was = prev_port[PORT_MSB - i];
					now_b = port[PORT_MSB - i];
					if (m == MODE_EVENT && was != now_b) begin
						pend = 1'b1;
						lvl_mem[i] = now_b;
						stamp_mem[i] = tms;
					end else if (m == MODE_COUNTER && !was && now_b) begin
						edges_mem[i] = edges_mem[i] + 32'd1;
					end
				end
				prev_port = port;
				sample_total = sample_total + 32'd1;
			end
			OP_READ: begin
				if (ch < NUM_CH) begin
					r.level = lvl_mem[ch];
					r.stamp = stamp_mem[ch];
					r.count = edges_mem[ch];
					edges_mem[ch] = '0;
				end
			end
			OP_CLEAR: pend = 1'b0;
			default: ;
		endcase
		r.event_pending = pend;
		r.samples_seen = sample_total;
		return r;
	endfunction

	initial begin
		chan_modes = '0;
		prev_port = '0;
		pend = 1'b0;
		sample_total = '0;
		for (int i = 0; i < NUM_CH; i++) begin
			lvl_mem[i] = 1'b0;
			stamp_mem[i] = '0;
			edges_mem[i] = '0;
		end
	end

	// Checks output beats against the oldest expectation, then predicts accepted inputs.
	always @(posedge clk) begin
		result_t got, want, r;
		if (arst_n) begin
			if (cfg_wr_en)
				chan_modes = cfg_wr_data;
			if (m_axis_tvalid && m_axis_tready) begin
				got = result_t'(m_axis_tdata[$bits(result_t)-1:0]);
				if (results_due.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected result beat %h", got);
				end else begin
					want = results_due.pop_front();
					if (got.event_pending !== want.event_pending || got.level !== want.level
							|| got.stamp !== want.stamp || got.count !== want.count
							|| got.samples_seen !== want.samples_seen) begin
						errors++;
						if (errors <= 10)
							$display("mismatch: exp pend=%b lvl=%b st=%h cnt=%h smp=%h, got pend=%b lvl=%b st=%h cnt=%h smp=%h",
								want.event_pending, want.level, want.stamp, want.count,
								want.samples_seen, got.event_pending, got.level, got.stamp,
								got.count, got.samples_seen);
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				r = counter_result(s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[39:8],
					s_axis_tdata[42:40]);
				if (row_fixed)
					r = row_res;
				results_due.push_back(r);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n)
			m_axis_tready <= quiet || ($urandom_range(99) >= IDLE_PCT);
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("tb_top: errors");
			$finish;
		end
	end

	task automatic send_item(logic [1:0] op, logic [7:0] port, logic [31:0] tms,
			logic [2:0] ch, bit fixed, result_t res);
		if (!quiet) begin
			while ($urandom_range(99) < IDLE_PCT) begin
				s_axis_tvalid <= 1'b0;
				@(posedge clk);
			end
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {5'b0, ch, tms, port};
		s_axis_tuser <= op;
		row_fixed <= fixed;
		row_res <= res;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// Lets every outstanding result arrive, then waits for the output register.
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (results_due.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_modes(logic [15:0] v);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic add_item(logic [1:0] op, logic [7:0] port, logic [31:0] tms,
			logic [2:0] ch);
		stim_row_t s;
		s = '{default: '0};
		s.op = op;
		s.port = port;
		s.tms = tms;
		s.ch = ch;
		stim_rows.push_back(s);
	endtask

	task automatic add_fixed(logic [1:0] op, logic [7:0] port, logic [31:0] tms,
			logic [2:0] ch, result_t res);
		add_item(op, port, tms, ch);
		stim_rows[$].fixed = 1'b1;
		stim_rows[$].res = res;
	endtask

	task automatic add_cfg(logic [15:0] v);
		stim_row_t s;
		s = '{default: '0};
		s.is_cfg = 1'b1;
		s.modes = v;
		stim_rows.push_back(s);
	endtask

	initial begin
		logic [1:0]  op;
		logic [7:0]  port;
		logic [31:0] tms;
		int          pick;
		logic [15:0] modes;

		// Channels 0-3 capture events, channels 4-7 count rising edges.
		add_cfg(16'hAA55);
		add_fixed(OP_READ, 8'h00, 32'h0, 3'd0,
			mk_res(1'b0, 1'b0, 32'd0, 32'd0, 32'd0));
		add_fixed(OP_SAMPLE, 8'hFF, 32'hFFFF_FFFF, 3'd7,
			mk_res(1'b1, 1'b0, 32'd0, 32'd0, 32'd1));
		add_fixed(OP_READ, 8'h00, 32'h0, 3'd0,
			mk_res(1'b1, 1'b1, 32'hFFFF_FFFF, 32'd0, 32'd1));
		add_fixed(OP_READ, 8'h00, 32'h0, 3'd7,
			mk_res(1'b1, 1'b0, 32'd0, 32'd1, 32'd1));
		add_fixed(OP_READ, 8'h00, 32'h0, 3'd7,
			mk_res(1'b1, 1'b0, 32'd0, 32'd0, 32'd1));
		add_fixed(OP_CLEAR, 8'h00, 32'h0, 3'd0,
			mk_res(1'b0, 1'b0, 32'd0, 32'd0, 32'd1));
		add_fixed(OP_UNUSED, 8'hFF, 32'hFFFF_FFFF, 3'd7,
			mk_res(1'b0, 1'b0, 32'd0, 32'd0, 32'd1));
		add_item(OP_SAMPLE, 8'h00, 32'h0, 3'd0);
		add_item(OP_READ, 8'h00, 32'h0, 3'd3);
		add_item(OP_SAMPLE, 8'h0F, 32'h1234_5678, 3'd0);
		add_item(OP_SAMPLE, 8'h0F, 32'h1234_5679, 3'd0);
		add_item(OP_SAMPLE, 8'h5A, 32'h8000_0000, 3'd0);
		add_item(OP_READ, 8'hFF, 32'hFFFF_FFFF, 3'd4);
		add_item(OP_READ, 8'h00, 32'h0, 3'd1);
		add_item(OP_CLEAR, 8'hFF, 32'hFFFF_FFFF, 3'd7);
		// Mode 3 ignores every channel; counts from the counter mode linger.
		add_cfg(16'hFFFF);
		add_item(OP_SAMPLE, 8'h00, 32'h1, 3'd0);
		add_item(OP_SAMPLE, 8'hFF, 32'h2, 3'd0);
		add_item(OP_READ, 8'h00, 32'h0, 3'd6);
		add_item(OP_READ, 8'h00, 32'h0, 3'd2);
		add_cfg(16'h0000);
		add_item(OP_SAMPLE, 8'hF0, 32'h3, 3'd0);
		add_item(OP_READ, 8'h00, 32'h0, 3'd5);
		// The previous port must have followed the samples taken in ignored mode.
		add_cfg(16'h5555);
		add_item(OP_SAMPLE, 8'h0F, 32'h4, 3'd0);
		add_item(OP_READ, 8'h00, 32'h0, 3'd0);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (stim_rows[i]) begin
			if (stim_rows[i].is_cfg) begin
				drain();
				write_modes(stim_rows[i].modes);
			end else begin
				send_item(stim_rows[i].op, stim_rows[i].port, stim_rows[i].tms,
					stim_rows[i].ch, stim_rows[i].fixed, stim_rows[i].res);
			end
		end
		last_port = 8'h0F;
		now_ms = 32'h10;

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			case (ph)
				0: modes = 16'h0000;
				1: modes = 16'hFFFF;
				2: modes = 16'hAAAA;
				3: modes = 16'h5555;
				default: modes = 16'($urandom_range(16'hFFFF));
			endcase
			drain();
			write_modes(modes);
			quiet = (ph == 4);
			for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
				pick = $urandom_range(99);
				if (pick < 60)
					op = OP_SAMPLE;
				else if (pick < 85)
					op = OP_READ;
				else if (pick < 95)
					op = OP_CLEAR;
				else
					op = OP_UNUSED;
				if ($urandom_range(7) == 0)
					port = 8'($urandom_range(255));
				else
					port = last_port ^ 8'($urandom_range(255) & $urandom_range(255));
				if ($urandom_range(15) == 0)
					tms = $urandom();
				else
					tms = now_ms + $urandom_range(1000);
				if (op == OP_SAMPLE) begin
					last_port = port;
					now_ms = tms;
				end
				send_item(op, port, tms, 3'($urandom_range(7)), 1'b0, '0);
			end
		end
		quiet = 1'b0;
		drain();

		if (results_due.size() != 0)
			errors++;
		if (errors == 0) begin
			$display("tb_top: clean");
		end else begin
			$display("tb_top: errors");
		end
		$finish;
	end

endmodule
